FILE: hw/rtl/stu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stu_pkg: shared constants and types for the servo target update scanner
// Servo table geometry, field widths, opcodes and the command record that
// travels from the front end through the command queue to the back end.
// ---------------------------------------------------------------------------
package stu_pkg;

   // servo array geometry
   localparam int LEGS            = 6;
   localparam int JOINTS          = 3;
   localparam int NSERVO          = LEGS * JOINTS;
   localparam int SIDX_W          = (NSERVO > 1) ? $clog2(NSERVO) : 1;
   localparam int SCNT_W          = $clog2(NSERVO + 1);
   localparam int MIRROR_FROM_LEG = 3;
   localparam int MIRROR_IDX      = MIRROR_FROM_LEG * JOINTS;

   // field widths
   localparam int LEG_W      = 3;
   localparam int JOINT_W    = 2;
   localparam int ANGLE_W    = 10;
   localparam int DUR_W      = 15;
   localparam int ID_W       = 5;
   localparam int POS_W      = 10;
   localparam int SPEED_W    = 10;
   localparam int CENTER_W   = 10;
   localparam int SCALE_W    = 16;
   localparam int MAG_W      = 10;
   localparam int PROD_W     = SCALE_W + MAG_W;
   localparam int SUM_W      = POS_W + 2;
   localparam int DIV_STEPS  = SPEED_W;
   localparam int DCNT_W     = $clog2(DIV_STEPS + 1);

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   // command queue
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // opcodes and register indexes
   localparam logic OP_SET  = 1'b0;
   localparam logic OP_TICK = 1'b1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE  = 1'b1;

   localparam logic [CENTER_W-1:0] CENTER_RESET = 10'd512;
   localparam logic [SCALE_W-1:0]  SCALE_RESET  = 16'd1;
   localparam logic [POS_W-1:0]    POS_MAX      = 10'd1023;
   localparam logic [SPEED_W-1:0]  SPEED_MAX    = 10'd1023;
   localparam logic [SPEED_W-1:0]  SPEED_MIN    = 10'd1;

   typedef struct packed {
      logic                      tick;
      logic                      in_range;
      logic [SIDX_W-1:0]         idx;
      logic signed [ANGLE_W-1:0] angle;
      logic [DUR_W-1:0]          duration;
   } stu_cmd_type;

endpackage
`default_nettype wire

FILE: hw/rtl/servo_target_update_scanner_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// With the engine idle, a set-target transfer is written into the command queue, then popped into the tables.
// Update tick: the queue pop starts the scan, which steps past each unchanged servo; each changed
// servo is scanned, run through the serial divider steps and emitted. A saturating speed ends
// the divider early. A full 18-servo tick is lengthened by the divider and by result-side stalls.
// Input is taken while the 2-entry command queue has room.
// Reset (synchronous): all tables zero, center_offset 512, speed_scale 1.
// ---------------------------------------------------------------------------
// servo_target_update_scanner_unit: servo target store and update scanner
// Stores per-servo targets, and on each update tick emits position and speed
// commands for every servo whose target moved since it was last sent.
// ---------------------------------------------------------------------------
module servo_target_update_scanner_unit
   import stu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // leg[2:0], joint[4:3], angle[14:5],
                                                   // duration[29:15]
   input  wire logic                   req_tuser,  // operation: 0 set target, 1 tick
   // result stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,  // motor_id[4:0], position[14:5],
                                                   // speed[24:15]
   output logic                        rsp_tlast,  // last result of a scan
   // register writes
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   stu_cmd_type          push_cmd;
   stu_cmd_type          pop_cmd;
   logic                 q_push;
   logic                 q_pop;
   logic                 q_full;
   logic                 q_empty;

   logic [CENTER_W-1:0]  center_ff, center_in;
   logic [SCALE_W-1:0]   scale_ff, scale_in;

   // configuration registers; written by the user only while the block is idle, which it does not enforce
   always_comb begin
      center_in = center_ff;
      scale_in  = scale_ff;
      if (csr_we) begin
         case (csr_index)
            REG_CENTER: center_in = csr_wdata[CENTER_W-1:0];
            REG_SCALE:  scale_in  = csr_wdata[SCALE_W-1:0];
            default: begin
               center_in = center_ff;
               scale_in  = scale_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= CENTER_RESET;
         scale_ff  <= SCALE_RESET;
      end else begin
         center_ff <= center_in;
         scale_ff  <= scale_in;
      end
   end

   // front end: decode each request transfer into a queued command
   stu_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   // decoupling queue between intake and the scan engine
   stu_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .cmd_in  (push_cmd),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .cmd_out (pop_cmd)
   );

   // back end: tables, scan, divider and output register
   stu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_cmd      (pop_cmd),
      .q_pop      (q_pop),
      .center     (center_ff),
      .scale      (scale_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

FILE: hw/rtl/stu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stu_front: request intake and classification
// Unpacks a request transfer, checks the servo address and queues a command.
// ---------------------------------------------------------------------------
module stu_front
   import stu_pkg::*;
(
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // leg, joint, angle, duration
   input  wire logic                   req_tuser,  // operation
   input  wire logic                   q_full,
   output logic                        q_push,
   output stu_cmd_type                 q_cmd
);

   logic [LEG_W-1:0]   leg;
   logic [JOINT_W-1:0] joint;

   always_comb begin
      leg              = req_tdata[LEG_W-1:0];
      joint            = req_tdata[LEG_W+JOINT_W-1:LEG_W];
      q_cmd.tick       = (req_tuser == OP_TICK);
      q_cmd.in_range   = (32'(leg) < LEGS) && (32'(joint) < JOINTS);
      q_cmd.idx        = SIDX_W'(32'(leg) * JOINTS + 32'(joint));
      q_cmd.angle      = req_tdata[LEG_W+JOINT_W+ANGLE_W-1:LEG_W+JOINT_W];
      q_cmd.duration   = req_tdata[LEG_W+JOINT_W+ANGLE_W+DUR_W-1:LEG_W+JOINT_W+ANGLE_W];
      req_tready       = !q_full;
      q_push           = req_tvalid && !q_full;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/stu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stu_queue: command queue
// Short FIFO decoupling request intake from the scan engine.
// ---------------------------------------------------------------------------
module stu_queue
   import stu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  stu_cmd_type      cmd_in,
   output logic             full,
   input  wire logic        pop,
   output logic             empty,
   output stu_cmd_type      cmd_out
);

   stu_cmd_type          mem_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;

   always_comb begin
      full      = (32'(count_ff) == QDEPTH);
      empty     = (count_ff == '0);
      cmd_out   = mem_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QDEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QDEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/stu_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stu_back: servo tables and update scan engine
// Holds target, duration and sent angle per servo, walks the table on a tick
// and produces one command per changed servo through a serial divider.
// ---------------------------------------------------------------------------
module stu_back
   import stu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_empty,
   input  stu_cmd_type                 q_cmd,
   output logic                        q_pop,
   input  wire logic [CENTER_W-1:0]    center,
   input  wire logic [SCALE_W-1:0]     scale,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,  // motor_id, position, speed
   output logic                        rsp_tlast   // last
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic signed [ANGLE_W-1:0] tgt_ff  [NSERVO];
   logic [DUR_W-1:0]          dur_ff  [NSERVO];
   logic signed [ANGLE_W-1:0] sent_ff [NSERVO];

   logic [1:0]           state_ff, state_in;
   logic [SCNT_W-1:0]    idx_ff, idx_in;
   logic [LEG_W-1:0]     leg_ff, leg_in;
   logic [JOINT_W-1:0]   joint_ff, joint_in;
   logic [PROD_W-1:0]    rem_ff, rem_in;
   logic [PROD_W-1:0]    dvs_ff, dvs_in;
   logic [SPEED_W-1:0]   quo_ff, quo_in;
   logic [DCNT_W-1:0]    cnt_ff, cnt_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [SPEED_W-1:0]   rsp_speed_ff, rsp_speed_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                      set_wr;
   logic                      sent_wr;
   logic [SIDX_W-1:0]         rd_idx;
   logic signed [ANGLE_W-1:0] cur_tgt;
   logic signed [ANGLE_W-1:0] cur_sent;
   logic [DUR_W-1:0]          cur_dur;
   logic signed [ANGLE_W:0]   diff;
   logic signed [ANGLE_W:0]   diff_abs;
   logic [MAG_W-1:0]          mag;
   logic signed [SUM_W-1:0]   tgt_ext;
   logic signed [SUM_W-1:0]   pos_sum;
   logic [POS_W-1:0]          pos_sat;
   logic [NSERVO-1:0]         changed;
   logic                      later_any;
   logic                      slot_free;
   logic                      ge;

   always_comb begin
      rd_idx   = idx_ff[SIDX_W-1:0];
      cur_tgt  = tgt_ff[rd_idx];
      cur_sent = sent_ff[rd_idx];
      cur_dur  = dur_ff[rd_idx];

      diff     = {cur_sent[ANGLE_W-1], cur_sent} - {cur_tgt[ANGLE_W-1], cur_tgt};
      diff_abs = diff[ANGLE_W] ? -diff : diff;
      mag      = diff_abs[MAG_W-1:0];

      // legs on the far side are mounted mirrored
      tgt_ext = SUM_W'(cur_tgt);
      if (32'(idx_ff) >= MIRROR_IDX) begin
         pos_sum = $signed({2'b00, center}) - tgt_ext;
      end else begin
         pos_sum = $signed({2'b00, center}) + tgt_ext;
      end
      if (pos_sum < 0) begin
         pos_sat = '0;
      end else if (pos_sum > $signed(SUM_W'(POS_MAX))) begin
         pos_sat = POS_MAX;
      end else begin
         pos_sat = pos_sum[POS_W-1:0];
      end

      // changed flags and whether a changed servo follows the current one
      later_any = 1'b0;
      for (int i = 0; i < NSERVO; i++) begin
         changed[i] = (tgt_ff[i] != sent_ff[i]);
         if (changed[i] && (i > 32'(idx_ff))) begin
            later_any = 1'b1;
         end
      end

      ge        = (rem_ff >= dvs_ff);
      slot_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      leg_in       = leg_ff;
      joint_in     = joint_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_id_in    = rsp_id_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_last_in  = rsp_last_ff;
      q_pop        = 1'b0;
      set_wr       = 1'b0;
      sent_wr      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_cmd.tick) begin
                  idx_in   = '0;
                  leg_in   = '0;
                  joint_in = '0;
                  state_in = S_SCAN;
               end else begin
                  set_wr = q_cmd.in_range;
               end
            end
         end
         S_SCAN: begin
            if (32'(idx_ff) == NSERVO) begin
               state_in = S_IDLE;
            end else if (changed[rd_idx]) begin
               rem_in   = PROD_W'(scale) * PROD_W'(mag);
               dvs_in   = PROD_W'(cur_dur) << DIV_STEPS;
               cnt_in   = DCNT_W'(DIV_STEPS);
               quo_in   = '0;
               pos_in   = pos_sat;
               last_in  = !later_any;
               state_in = S_DIV;
            end else begin
               idx_in = idx_ff + 1'b1;
               if (32'(joint_ff) == JOINTS - 1) begin
                  joint_in = '0;
                  leg_in   = leg_ff + 1'b1;
               end else begin
                  joint_in = joint_ff + 1'b1;
               end
            end
         end
         S_DIV: begin
            dvs_in = dvs_ff >> 1;
            if (32'(cnt_ff) == DIV_STEPS) begin
               // quotient overflow check; zero duration gives dvs 0 and lands here
               if (ge) begin
                  quo_in   = SPEED_MAX;
                  state_in = S_EMIT;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end else begin
               if (ge) begin
                  rem_in = rem_ff - dvs_ff;
               end
               quo_in = {quo_ff[SPEED_W-2:0], ge};
               if (cnt_ff == '0) begin
                  state_in = S_EMIT;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = {leg_ff, joint_ff};
               rsp_pos_in   = pos_ff;
               rsp_speed_in = (quo_ff == '0) ? SPEED_MIN : quo_ff;
               rsp_last_in  = last_ff;
               sent_wr      = 1'b1;
               idx_in       = idx_ff + 1'b1;
               if (32'(joint_ff) == JOINTS - 1) begin
                  joint_in = '0;
                  leg_in   = leg_ff + 1'b1;
               end else begin
                  joint_in = joint_ff + 1'b1;
               end
               state_in = S_SCAN;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = {(RSP_TDATA_W - ID_W - POS_W - SPEED_W)'(0), rsp_speed_ff, rsp_pos_ff,
                    rsp_id_ff};
      rsp_tlast  = rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         leg_ff       <= '0;
         joint_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         leg_ff       <= leg_in;
         joint_ff     <= joint_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      quo_ff       <= quo_in;
      pos_ff       <= pos_in;
      last_ff      <= last_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // servo tables, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSERVO; i++) begin
            tgt_ff[i]  <= '0;
            dur_ff[i]  <= '0;
            sent_ff[i] <= '0;
         end
      end else begin
         if (set_wr) begin
            tgt_ff[q_cmd.idx] <= q_cmd.angle;
            dur_ff[q_cmd.idx] <= q_cmd.duration;
         end
         if (sent_wr) begin
            sent_ff[rd_idx] <= cur_tgt;
         end
      end
   end

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (32'(cnt_ff) <= DIV_STEPS))
      else $error("divider step count out of range");

   a_speed_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_speed_ff != '0))
      else $error("speed of zero presented");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_EMIT))
      else $error("result appeared outside of emit");

   a_scan_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (32'(idx_ff) <= NSERVO))
      else $error("scan index past table end");

endmodule
`default_nettype wire
